// ===== hdl/signed_int_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for signed_int_to_decimal_ascii
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SITDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication from one cycle to the next, outside reset.
`define SITDA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (prop)) else $error(msg);

`endif

// ===== hdl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes and BCD helpers for the integer to text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // Width of the signed input word.
  localparam int ValueWidth    = 32;
  // A 32-bit magnitude has at most ten decimal digits.
  localparam int BcdDigits     = 10;
  localparam int BcdWidth      = 4 * BcdDigits;
  localparam int BitCntWidth   = $clog2(ValueWidth);
  localparam int DigitCntWidth = $clog2(BcdDigits + 1);
  localparam int CharWidth     = 8;

  // ASCII codes used in the output text.
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharNine  = 8'd57;

  // Double dabble correction: every digit of five or more gets three added,
  // so that the following left shift carries correctly into the next digit.
  function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] bcd);
    logic [BcdWidth-1:0] res;
    res = bcd;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // True when every digit of the word lies in the range nought to nine.
  function automatic logic bcd_is_valid(input logic [BcdWidth-1:0] bcd);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text, one character
// per output beat, most significant character first.
// ----------------------------------------------------------------------------
// One input beat carries a two's complement integer; the block answers with
// its decimal text, a leading '-' for negative values and no leading zeros,
// and tlast marks the final digit. The magnitude is converted bit-serially by
// double dabble, one input bit per cycle, into the conversion shift register;
// then the leading zeros are dropped (up to nine), and then the characters
// are handed out while the sink is ready. The input is held off from the
// moment a value is taken until its last character has been loaded into the
// output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: [31:0] value (signed).
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,
  // Output stream. tdata: [7:0] char_code. tlast: last_char.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  // Controller states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  localparam logic [sitda_pkg::BitCntWidth-1:0] LastStep =
    sitda_pkg::BitCntWidth'(sitda_pkg::ValueWidth - 1);
  localparam logic [sitda_pkg::DigitCntWidth-1:0] AllDigits =
    sitda_pkg::DigitCntWidth'(sitda_pkg::BcdDigits);
  localparam logic [sitda_pkg::DigitCntWidth-1:0] OneDigit =
    sitda_pkg::DigitCntWidth'(1);

  logic [2:0]                               state_q, state_d;
  logic [sitda_pkg::ValueWidth-1:0]         mag_q, mag_d;
  logic [sitda_pkg::BcdWidth-1:0]           bcd_q, bcd_d;
  logic [sitda_pkg::BitCntWidth-1:0]        cnt_q, cnt_d;
  logic [sitda_pkg::DigitCntWidth-1:0]      ndig_q, ndig_d;
  logic                                     neg_q, neg_d;
  logic                                     out_valid_q, out_valid_d;
  logic [sitda_pkg::CharWidth-1:0]          out_char_q, out_char_d;
  logic                                     out_last_q, out_last_d;

  logic                                     in_beat;
  logic                                     slot_free;
  logic [sitda_pkg::BcdWidth-1:0]           bcd_adj;
  logic [3:0]                               top_digit;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign bcd_adj         = sitda_pkg::bcd_adjust(bcd_q);
  assign top_digit       = bcd_q[sitda_pkg::BcdWidth-1 -: 4];

  // Sequencer: load, shift the magnitude into the BCD register, drop leading
  // zeros, then hand characters to the output register.
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      StIdle: begin
        if (in_beat) begin
          neg_d   = s_axis_tdata_i[sitda_pkg::ValueWidth-1];
          mag_d   = neg_d ? (~s_axis_tdata_i + 32'd1) : s_axis_tdata_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = {bcd_adj[sitda_pkg::BcdWidth-2:0], mag_q[sitda_pkg::ValueWidth-1]};
        mag_d = {mag_q[sitda_pkg::ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          ndig_d  = AllDigits;
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Zero keeps its single digit.
        if (top_digit == 4'd0 && ndig_q != OneDigit) begin
          bcd_d  = {bcd_q[sitda_pkg::BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CharMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sitda_pkg::CharZero + {4'd0, top_digit};
          out_last_d  = (ndig_q == OneDigit);
          bcd_d       = {bcd_q[sitda_pkg::BcdWidth-5:0], 4'd0};
          ndig_d      = ndig_q - 1'b1;
          if (ndig_q == OneDigit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    ndig_q     <= ndig_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

  // Checks on the conversion and the text it produces.
  `SITDA_ASSERT(a_bcd_digits_valid,
    !(state_q == StSkip || state_q == StSign || state_q == StEmit) ||
    sitda_pkg::bcd_is_valid(bcd_q),
    "BCD register holds a digit above nine")
  `SITDA_ASSERT(a_char_in_set,
    !m_axis_tvalid_o || m_axis_tdata_o == sitda_pkg::CharMinus ||
    (m_axis_tdata_o >= sitda_pkg::CharZero && m_axis_tdata_o <= sitda_pkg::CharNine),
    "output character is neither a digit nor a minus sign")
  `SITDA_ASSERT(a_minus_not_last,
    !(m_axis_tvalid_o && m_axis_tdata_o == sitda_pkg::CharMinus) || !m_axis_tlast_o,
    "minus sign marked as last character")
  `SITDA_ASSERT_NEXT(a_emit_ends_idle,
    state_q == StEmit && slot_free && ndig_q == OneDigit,
    state_q == StIdle && m_axis_tvalid_o && m_axis_tlast_o,
    "final digit did not close the text")

endmodule

// ===== bench/tb_signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
// Integers are sent one per input beat and the expected text of each value is
// worked out in the bench as soon as the beat is taken. Every output beat is
// compared, character code and tlast apart, with the oldest character still
// awaited. A directed set covers the sign, zero, the largest and smallest
// words and every digit; random values of every length and random raw words
// follow. The source and the sink back off at random in three settings:
// mostly idle source, mostly stalled sink, and neither.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 60;

  // One character of the expected text.
  typedef struct packed {
    logic [sitda_pkg::CharWidth-1:0] code;
    logic                            last;
  } text_char_t;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [sitda_pkg::ValueWidth-1:0] s_axis_tdata_i  = '0;  // [31:0] value (signed)
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [sitda_pkg::CharWidth-1:0]  m_axis_tdata_o;        // [7:0] char_code
  logic                             m_axis_tlast_o;        // last_char

  text_char_t expected_text[$];
  text_char_t wanted_char;
  int         send_idle_pct   = 0;
  int         sink_stall_pct  = 0;
  int         error_count     = 0;
  int         values_sent     = 0;
  int         negatives_sent  = 0;
  int         chars_checked   = 0;
  int         quiet_cycles    = 0;

  signed_int_to_decimal_ascii DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Works out the decimal text of one word and queues its characters.
  function automatic void predict_decimal_text(
    input logic [sitda_pkg::ValueWidth-1:0] word
  );
    logic [sitda_pkg::ValueWidth-1:0] magnitude;
    logic [3:0]                       digits[sitda_pkg::BcdDigits];
    int                               ndigits;
    text_char_t                       ch;
    magnitude = word[sitda_pkg::ValueWidth-1] ? (~word + 1'b1) : word;
    ndigits   = 0;
    // Digits come out least significant first.
    do begin
      digits[ndigits] = 4'(magnitude % 10);
      magnitude       = magnitude / 10;
      ndigits++;
    end while (magnitude != 0);
    if (word[sitda_pkg::ValueWidth-1]) begin
      ch.code = sitda_pkg::CharMinus;
      ch.last = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      ch.code = sitda_pkg::CharZero + sitda_pkg::CharWidth'(digits[i]);
      ch.last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // Sends one value, idling beforehand at the current rate, and waits for
  // the beat to be taken. tvalid is left high for a following value.
  task automatic send_value(input logic [sitda_pkg::ValueWidth-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    values_sent++;
    if (word[sitda_pkg::ValueWidth-1]) negatives_sent++;
  endtask

  // Edge values, the sign, zero and every digit.
  task automatic test_directed_extremes();
    logic [sitda_pkg::ValueWidth-1:0] words[$];
    words = {32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
             32'h5555_5555, 32'hAAAA_AAAA, -32'sd5, 32'd1000, 32'd876543210,
             -32'sd7};
    foreach (words[i]) send_value(words[i]);
  endtask

  // Values of a random length from one to ten digits and a random sign.
  task automatic test_random_lengths(input int count);
    longint lo;
    longint hi;
    longint mag;
    int     ndigits;
    bit     negative;
    for (int n = 0; n < count; n++) begin
      ndigits  = $urandom_range(10, 1);
      negative = 1'($urandom_range(1));
      lo = 1;
      for (int d = 1; d < ndigits; d++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndigits == 1) lo = 0;
      if (negative && hi > 64'd2147483648) hi = 64'd2147483648;
      if (!negative && hi > 64'd2147483647) hi = 64'd2147483647;
      mag = lo + longint'($urandom_range(32'(hi - lo)));
      send_value(negative ? sitda_pkg::ValueWidth'(-mag) : sitda_pkg::ValueWidth'(mag));
    end
  endtask

  // Raw random words, so that every input bit takes both values.
  task automatic test_random_words(input int count);
    for (int n = 0; n < count; n++) send_value($urandom());
  endtask

  // The sink stalls at random at the current rate.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Each value taken on the input adds its text to the characters awaited.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_decimal_text(s_axis_tdata_i);
    end
  end

  // Each output beat is checked against the oldest character awaited.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, char 0x%02h last %0b",
                                  m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        wanted_char = expected_text.pop_front();
        chars_checked++;
        if (m_axis_tdata_o !== wanted_char.code) begin
          report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                    m_axis_tdata_o, wanted_char.code));
        end
        if (m_axis_tlast_o !== wanted_char.last) begin
          report_mismatch($sformatf("tlast %0b, expected %0b",
                                    m_axis_tlast_o, wanted_char.last));
        end
      end
    end
  end

  // Ends the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no beat moved for %0d cycles", WatchdogLimit);
      $display("FAIL signed_int_to_decimal_ascii");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lightly idle source, heavily stalled sink.
    send_idle_pct  = 24;
    sink_stall_pct = 87;
    test_directed_extremes();
    test_random_lengths(40);
    test_random_words(30);

    // Heavily idle source, mostly ready sink.
    send_idle_pct  = 87;
    sink_stall_pct = 24;
    test_random_lengths(40);
    test_random_words(30);

    // Back to back on both sides.
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    test_random_lengths(40);
    test_random_words(30);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);

    // Let the remaining text drain, then allow for any stray beats.
    while (expected_text.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
    end

    $display("Converted %0d values (%0d negative) and checked %0d characters,",
             values_sent, negatives_sent, chars_checked);
    $display("under idle source, stalled sink and back-to-back traffic; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sitda_pkg.sv
hdl/signed_int_to_decimal_ascii.sv
bench/tb_signed_int_to_decimal_ascii.sv
